@@ design/hcsp_pkg.sv @@
// ----------------------------------------------------------------------------
// hcsp_pkg: shared definitions for the hex colour string parser
// Character codes, field widths, result format codes and the hex digit decode
// used by the scan stage and the result formatter.
// ----------------------------------------------------------------------------
package hcsp_pkg;

   localparam int CHAR_W      = 8;
   localparam int CHAN_W      = 8;
   localparam int VALUE_W     = 32;
   localparam int DIGIT_W     = 4;
   localparam int HEX_COUNT_W = 4;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_HASH  = 8'h23;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LO_F  = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UP_F  = 8'h46;

   // Digit run length at which scanning stops, and the valid run lengths.
   localparam logic [HEX_COUNT_W-1:0] MAX_DIGITS   = 4'd9;
   localparam logic [HEX_COUNT_W-1:0] COUNT_RGB    = 4'd3;
   localparam logic [HEX_COUNT_W-1:0] COUNT_RRGGBB = 4'd6;
   localparam logic [HEX_COUNT_W-1:0] COUNT_ARGB   = 4'd8;

   localparam logic [CHAN_W-1:0] CHAN_FULL  = 8'hFF;
   localparam logic [CHAN_W-1:0] CHAN_EMPTY = 8'h00;

   typedef enum logic [1:0] {
      FMT_FALLBACK = 2'd0,
      FMT_RGB      = 2'd1,
      FMT_RRGGBB   = 2'd2,
      FMT_AARRGGBB = 2'd3
   } format_kind_type;

   typedef struct packed {
      logic is_hex;
      logic [DIGIT_W-1:0] digit;
   } hex_digit_type;

   // Scan state as seen by the formatter and the checks at the top level.
   typedef struct packed {
      logic                   at_first_char;
      logic [HEX_COUNT_W-1:0] hex_count;
      logic                   scan_stopped;
      logic                   non_hex_seen;
      logic [VALUE_W-1:0]     accumulated_value;
   } scan_status_type;

   function automatic hex_digit_type hex_decode(input logic [CHAR_W-1:0] ch);
      hex_digit_type res;
      logic [CHAR_W-1:0] diff;
      res  = '{is_hex: 1'b0, digit: '0};
      diff = '0;
      priority if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         diff = ch - CHAR_ZERO;
         res  = '{is_hex: 1'b1, digit: diff[DIGIT_W-1:0]};
      end else if (ch >= CHAR_LO_A && ch <= CHAR_LO_F) begin
         diff = ch - CHAR_LO_A + 8'd10;
         res  = '{is_hex: 1'b1, digit: diff[DIGIT_W-1:0]};
      end else if (ch >= CHAR_UP_A && ch <= CHAR_UP_F) begin
         diff = ch - CHAR_UP_A + 8'd10;
         res  = '{is_hex: 1'b1, digit: diff[DIGIT_W-1:0]};
      end else begin
         res = '{is_hex: 1'b0, digit: '0};
      end
      return res;
   endfunction

endpackage

@@ design/hcsp_if.sv @@
// ----------------------------------------------------------------------------
// hcsp_if: channel interfaces of the hex colour string parser
// Valid/ready channels for the character items in and the colour items out.
// ----------------------------------------------------------------------------
interface hcsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;

   modport source (output valid, output character, input ready);
   modport sink   (input valid, input character, output ready);
endinterface

interface hcsp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] alpha;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [1:0] format_kind;
   logic       strictly_valid;

   modport source (output valid, output alpha, output red, output green, output blue,
                   output format_kind, output strictly_valid, input ready);
   modport sink   (input valid, input alpha, input red, input green, input blue,
                   input format_kind, input strictly_valid, output ready);
endinterface

@@ design/hcsp_scan.sv @@
// ----------------------------------------------------------------------------
// hcsp_scan: input register and digit scan
// Holds one character item and folds it into the running scan state; a
// terminator is handed to the formatter and clears the scan state.
// ----------------------------------------------------------------------------
module hcsp_scan
   import hcsp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   hcsp_req_if.sink        req_channel,
   input  logic            out_free,
   output logic            term_load,
   output scan_status_type status
);

   logic                   in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0]      char_ff, char_in;
   logic                   at_first_ff, at_first_in;
   logic [HEX_COUNT_W-1:0] count_ff, count_in;
   logic                   stopped_ff, stopped_in;
   logic                   non_hex_ff, non_hex_in;
   logic [VALUE_W-1:0]     value_ff, value_in;

   logic                   advance;
   logic                   accept;
   logic                   is_term;
   logic [HEX_COUNT_W-1:0] count_inc;
   hex_digit_type          dec;

   assign is_term   = (char_ff == CHAR_NUL);
   // A plain character never waits; a terminator waits for the result register.
   assign advance   = in_valid_ff && (!is_term || out_free);
   assign req_channel.ready = !in_valid_ff || advance;
   assign accept    = req_channel.valid && req_channel.ready;
   assign term_load = in_valid_ff && is_term && out_free;
   assign dec       = hex_decode(char_ff);
   assign count_inc = count_ff + 4'd1;

   always_comb begin
      in_valid_in = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      char_in     = accept ? req_channel.character : char_ff;
      at_first_in = at_first_ff;
      count_in    = count_ff;
      stopped_in  = stopped_ff;
      non_hex_in  = non_hex_ff;
      value_in    = value_ff;
      if (advance) begin
         if (is_term) begin
            at_first_in = 1'b1;
            count_in    = '0;
            stopped_in  = 1'b0;
            non_hex_in  = 1'b0;
            value_in    = '0;
         end else begin
            at_first_in = 1'b0;
            if (!(at_first_ff && char_ff == CHAR_HASH)) begin
               if (!dec.is_hex) begin
                  non_hex_in = 1'b1;
                  stopped_in = 1'b1;
               end else if (!stopped_ff) begin
                  value_in = {value_ff[VALUE_W-DIGIT_W-1:0], dec.digit};
                  count_in = count_inc;
                  if (count_inc >= MAX_DIGITS) begin
                     stopped_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         at_first_ff <= 1'b1;
         count_ff    <= '0;
         stopped_ff  <= 1'b0;
         non_hex_ff  <= 1'b0;
         value_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         at_first_ff <= at_first_in;
         count_ff    <= count_in;
         stopped_ff  <= stopped_in;
         non_hex_ff  <= non_hex_in;
         value_ff    <= value_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
   end

   assign status = '{at_first_char:     at_first_ff,
                     hex_count:         count_ff,
                     scan_stopped:      stopped_ff,
                     non_hex_seen:      non_hex_ff,
                     accumulated_value: value_ff};

endmodule

@@ design/hcsp_format.sv @@
// ----------------------------------------------------------------------------
// hcsp_format: colour decode and result register
// Turns the digit count and accumulated value into a colour item and holds it
// until the consumer takes it.
// ----------------------------------------------------------------------------
module hcsp_format
   import hcsp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            term_load,
   input  scan_status_type status,
   hcsp_rsp_if.source      rsp_channel,
   output logic            out_free
);

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0] alpha_ff, alpha_in;
   logic [CHAN_W-1:0] red_ff, red_in;
   logic [CHAN_W-1:0] green_ff, green_in;
   logic [CHAN_W-1:0] blue_ff, blue_in;
   format_kind_type   kind_ff, kind_in;
   logic              strict_ff, strict_in;
   logic [VALUE_W-1:0] v;

   assign v        = status.accumulated_value;
   assign out_free = !rsp_valid_ff || rsp_channel.ready;

   always_comb begin
      rsp_valid_in = term_load ? 1'b1 : (rsp_channel.ready ? 1'b0 : rsp_valid_ff);
      alpha_in = CHAN_FULL;
      red_in   = CHAN_FULL;
      green_in = CHAN_EMPTY;
      blue_in  = CHAN_FULL;
      kind_in  = FMT_FALLBACK;
      unique case (status.hex_count)
         COUNT_RGB: begin
            // A nibble times 17 is the nibble written twice.
            red_in   = {v[11:8], v[11:8]};
            green_in = {v[7:4], v[7:4]};
            blue_in  = {v[3:0], v[3:0]};
            kind_in  = FMT_RGB;
         end
         COUNT_RRGGBB: begin
            red_in   = v[23:16];
            green_in = v[15:8];
            blue_in  = v[7:0];
            kind_in  = FMT_RRGGBB;
         end
         COUNT_ARGB: begin
            alpha_in = v[31:24];
            red_in   = v[23:16];
            green_in = v[15:8];
            blue_in  = v[7:0];
            kind_in  = FMT_AARRGGBB;
         end
         default: begin
            kind_in = FMT_FALLBACK;
         end
      endcase
      strict_in = (kind_in != FMT_FALLBACK) && !status.non_hex_seen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (term_load) begin
         alpha_ff  <= alpha_in;
         red_ff    <= red_in;
         green_ff  <= green_in;
         blue_ff   <= blue_in;
         kind_ff   <= kind_in;
         strict_ff <= strict_in;
      end
   end

   assign rsp_channel.valid          = rsp_valid_ff;
   assign rsp_channel.alpha          = alpha_ff;
   assign rsp_channel.red            = red_ff;
   assign rsp_channel.green          = green_ff;
   assign rsp_channel.blue           = blue_ff;
   assign rsp_channel.format_kind    = kind_ff;
   assign rsp_channel.strictly_valid = strict_ff;

endmodule

@@ design/hex_color_string_parser_unit.sv @@
// ----------------------------------------------------------------------------
// hex_color_string_parser_unit: hex colour string parser
// Parses a zero-terminated colour string, one character per item, into an
// alpha/red/green/blue colour item with its format and a strict-validity flag.
// ----------------------------------------------------------------------------
//
//   Channel       Direction  Payload                                  Items
//   req_channel   in         character[7:0]                           one per byte
//   rsp_channel   out        alpha, red, green, blue, format_kind,    one per
//                            strictly_valid                           terminator
//
// One character item is accepted every cycle unless a terminator waits for the
// result register; the digit decode, shift and count update happen in the input
// register, and a terminator loads the result register from there when it is free.
// Reset is synchronous and active high; it empties both registers and returns
// the scan to the start of a string.
// A stalled result holds only terminators back: ordinary characters keep
// flowing while a finished colour item waits in the result register.
//
module hex_color_string_parser_unit
   import hcsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   hcsp_req_if.sink   req_channel,
   hcsp_rsp_if.source rsp_channel
);

   // Handshake between the scan stage and the result register.
   logic            term_load;
   logic            out_free;
   scan_status_type status;

   // The scan stage keeps the input register and the running digit state.
   hcsp_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_channel),
      .out_free    (out_free),
      .term_load   (term_load),
      .status      (status)
   );

   // The formatter decodes the finished scan and holds the colour item.
   hcsp_format u_format (
      .clock       (clock),
      .reset       (reset),
      .term_load   (term_load),
      .status      (status),
      .rsp_channel (rsp_channel),
      .out_free    (out_free)
   );

`ifndef NO_ASSERTIONS
   // Loading a result must leave the scan ready for a fresh string.
   a_clear_after_term: assert property (@(posedge clock) disable iff (reset)
      term_load |=> (status.at_first_char && status.hex_count == '0 &&
                     !status.scan_stopped && !status.non_hex_seen))
      else $error("scan state not cleared after a terminator");

   // The digit count saturates at the stop length and stops the scan there.
   a_count_stops: assert property (@(posedge clock) disable iff (reset)
      status.hex_count >= MAX_DIGITS |-> (status.hex_count == MAX_DIGITS &&
                                          status.scan_stopped))
      else $error("digit count overran or scan not stopped");

   // A strictly valid colour item never carries the fallback format.
   a_strict_format: assert property (@(posedge clock) disable iff (reset)
      (rsp_channel.valid && rsp_channel.strictly_valid) |->
         (rsp_channel.format_kind != FMT_FALLBACK))
      else $error("strictly valid item with fallback format");
`endif

endmodule

@@ tb/hex_color_string_parser_unit_test.sv @@
// ----------------------------------------------------------------------------
// hex_color_string_parser_unit_test: self-checking bench for the colour parser
// Feeds zero-terminated colour strings one character item at a time, predicts
// every colour item from its own model of the scan, and checks each colour
// item the block returns, under several patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module hex_color_string_parser_unit_test;
   import hcsp_pkg::*;

   localparam int          PHASE_ITEMS  = 382;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          DRAIN_CYCLES = 20;
   localparam int unsigned CYCLE_LIMIT  = 300000;
   localparam logic [CHAN_W-1:0] NIBBLE_SCALE = 8'd17;

   // One colour item as the block should return it.
   typedef struct {
      logic [CHAN_W-1:0] alpha;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      format_kind_type   kind;
      logic              strict;
   } colour_type;

   logic clock;
   logic reset;

   hcsp_req_if req_channel();
   hcsp_rsp_if rsp_channel();

   hex_color_string_parser_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_channel),
      .rsp_channel (rsp_channel)
   );

   // Characters waiting to be offered, and colour items predicted but not yet seen.
   logic [CHAR_W-1:0] pending_characters[$];
   colour_type        expected_colours[$];

   int unsigned items_queued;
   int unsigned mismatch_count;
   int unsigned cycle_count;

   // Idling percentages for the current phase, set by the stimulus process.
   int unsigned sender_idle_pct;
   int unsigned receiver_stall_pct;

   // Long receiver hold-offs: the stimulus process asks, the receiver grants.
   int unsigned holds_asked;
   int unsigned holds_granted;
   int unsigned hold_left;

   // Our own copy of the scan state, advanced on every accepted character item.
   logic                   fresh_string;
   logic [HEX_COUNT_W-1:0] digit_total;
   logic                   scan_halted;
   logic [VALUE_W-1:0]     digit_value;
   logic                   stray_byte_seen;

   colour_type wanted_colour;

   // Returns {is_hex, nibble}; the top bit is low for anything but 0-9, a-f, A-F.
   function automatic logic [DIGIT_W:0] nibble_of(input logic [CHAR_W-1:0] ch);
      logic [CHAR_W-1:0] offset;
      logic [DIGIT_W:0]  res;
      res    = '0;
      offset = '0;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         offset = ch - CHAR_ZERO;
         res    = {1'b1, offset[DIGIT_W-1:0]};
      end else if (ch >= CHAR_LO_A && ch <= CHAR_LO_F) begin
         offset = ch - CHAR_LO_A + 8'd10;
         res    = {1'b1, offset[DIGIT_W-1:0]};
      end else if (ch >= CHAR_UP_A && ch <= CHAR_UP_F) begin
         offset = ch - CHAR_UP_A + 8'd10;
         res    = {1'b1, offset[DIGIT_W-1:0]};
      end
      return res;
   endfunction

   task automatic clear_scan();
      fresh_string    = 1'b1;
      digit_total     = '0;
      scan_halted     = 1'b0;
      digit_value     = '0;
      stray_byte_seen = 1'b0;
   endtask

   // Advances the scan by one accepted character; a terminator closes the
   // string, queues the colour item it should produce and starts a new scan.
   task automatic absorb_character(input logic [CHAR_W-1:0] ch);
      logic             was_fresh;
      logic [DIGIT_W:0] decoded;
      colour_type       colour;
      if (ch != CHAR_NUL) begin
         was_fresh    = fresh_string;
         fresh_string = 1'b0;
         // A leading hash is simply dropped; anywhere else it is a stray byte.
         if (!(was_fresh && ch == CHAR_HASH)) begin
            decoded = nibble_of(ch);
            if (!decoded[DIGIT_W]) begin
               stray_byte_seen = 1'b1;
               scan_halted     = 1'b1;
            end else if (!scan_halted) begin
               digit_value = {digit_value[VALUE_W-DIGIT_W-1:0], decoded[DIGIT_W-1:0]};
               digit_total = digit_total + 1'b1;
               if (digit_total >= MAX_DIGITS)
                  scan_halted = 1'b1;
            end
         end
      end else begin
         colour = '{alpha: CHAN_FULL, red: CHAN_FULL, green: CHAN_EMPTY,
                    blue: CHAN_FULL, kind: FMT_FALLBACK, strict: 1'b0};
         case (digit_total)
            COUNT_RGB: begin
               // Short form: each nibble is stretched to a byte by times 17.
               colour.red   = {4'h0, digit_value[11:8]} * NIBBLE_SCALE;
               colour.green = {4'h0, digit_value[7:4]} * NIBBLE_SCALE;
               colour.blue  = {4'h0, digit_value[3:0]} * NIBBLE_SCALE;
               colour.kind  = FMT_RGB;
            end
            COUNT_RRGGBB: begin
               colour.red   = digit_value[23:16];
               colour.green = digit_value[15:8];
               colour.blue  = digit_value[7:0];
               colour.kind  = FMT_RRGGBB;
            end
            COUNT_ARGB: begin
               colour.alpha = digit_value[31:24];
               colour.red   = digit_value[23:16];
               colour.green = digit_value[15:8];
               colour.blue  = digit_value[7:0];
               colour.kind  = FMT_AARRGGBB;
            end
            default: begin
            end
         endcase
         colour.strict = (colour.kind != FMT_FALLBACK) && !stray_byte_seen;
         expected_colours.push_back(colour);
         clear_scan();
      end
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("cycle %0d: %s", cycle_count, what);
   endtask

   task automatic check_field(input string field, input int unsigned got,
                              input int unsigned want, input logic known);
      if (!known || got != want)
         report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
   endtask

   // ------------------------------------------------------------------------
   // Stimulus building
   // ------------------------------------------------------------------------

   task automatic add_character(input logic [CHAR_W-1:0] ch);
      pending_characters.push_back(ch);
      items_queued++;
   endtask

   // Queues the text followed by its terminator.
   task automatic add_string(input string text);
      for (int i = 0; i < text.len(); i++)
         add_character(text[i]);
      add_character(CHAR_NUL);
   endtask

   function automatic logic [CHAR_W-1:0] random_hex_character();
      logic [CHAR_W-1:0] d;
      d = CHAR_W'($urandom_range(0, 15));
      if (d < 10)
         return CHAR_ZERO + d;
      else if ($urandom_range(0, 1))
         return CHAR_LO_A + d - 8'd10;
      else
         return CHAR_UP_A + d - 8'd10;
   endfunction

   // Any non-zero byte that is not a hex digit, with the hash favoured.
   function automatic logic [CHAR_W-1:0] random_stray_character();
      logic [CHAR_W-1:0] ch;
      logic [DIGIT_W:0]  decoded;
      if ($urandom_range(0, 3) == 0)
         return CHAR_HASH;
      do begin
         ch      = CHAR_W'($urandom_range(1, 255));
         decoded = nibble_of(ch);
      end while (decoded[DIGIT_W]);
      return ch;
   endfunction

   // Mostly well-formed colours with random digits, some with a stray byte
   // dropped in somewhere, and the rest plain noise.
   task automatic add_random_string();
      int unsigned shape;
      int unsigned n_digits;
      int unsigned stray_pos;
      int unsigned n_noise;
      shape = $urandom_range(0, 99);
      if (shape < 80) begin
         if ($urandom_range(0, 1))
            add_character(CHAR_HASH);
         case ($urandom_range(0, 9))
            0, 1, 2: n_digits = 3;
            3, 4, 5: n_digits = 6;
            6, 7:    n_digits = 8;
            default: n_digits = $urandom_range(0, 11);
         endcase
         stray_pos = (shape >= 60) ? $urandom_range(0, n_digits) : n_digits + 1;
         for (int k = 0; k < n_digits; k++) begin
            if (k == stray_pos)
               add_character(random_stray_character());
            add_character(random_hex_character());
         end
         if (stray_pos == n_digits)
            add_character(random_stray_character());
         add_character(CHAR_NUL);
      end else begin
         n_noise = $urandom_range(0, 10);
         for (int k = 0; k < n_noise; k++)
            add_character(CHAR_W'($urandom_range(1, 255)));
         add_character(CHAR_NUL);
      end
   endtask

   // Sets the idling for one phase, queues its strings and waits until the
   // driver has taken every character of them.
   task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                            input logic long_hold);
      int unsigned target;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      if (long_hold)
         holds_asked++;
      target = items_queued + PHASE_ITEMS;
      while (items_queued < target)
         add_random_string();
      while (pending_characters.size() != 0)
         @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Clock, reset and run control
   // ------------------------------------------------------------------------

   always #6 clock = ~clock;

   initial begin
      clock                   = 1'b0;
      reset                   = 1'b1;
      req_channel.valid       = 1'b0;
      req_channel.character   = CHAR_NUL;
      rsp_channel.ready       = 1'b0;
      items_queued            = 0;
      mismatch_count          = 0;
      cycle_count             = 0;
      sender_idle_pct         = 0;
      receiver_stall_pct      = 0;
      holds_asked             = 0;
      holds_granted           = 0;
      hold_left               = 0;
      clear_scan();

      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed strings, offered back to back: short form behind a hash,
      // an empty string, a hash with nothing after it, the six- and
      // eight-digit forms with mixed case, a digit run too long to parse
      // followed by the largest byte value, and a hash in the middle.
      add_string("#fA0");
      add_string("");
      add_string("#");
      add_string("0Ff7e9");
      add_string("aBcd0189");
      add_string("9aBcDeF01\377");
      add_string("a#");
      while (pending_characters.size() != 0)
         @(negedge clock);

      // Random strings under each idling pattern, then a phase in which the
      // receiver stops for a long while so the block backs up onto its input.
      run_phase(0, 0, 1'b0);
      run_phase(66, 0, 1'b0);
      run_phase(0, 66, 1'b0);
      run_phase(33, 33, 1'b0);
      run_phase(0, 0, 1'b1);

      // Let the last character go in and every colour item come out.
      while (req_channel.valid)
         @(negedge clock);
      while (expected_colours.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Guards against a block that stops answering.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Driver: offers queued characters, holding each one until it is taken.
   // An accepted character is handed to the model at the same edge, so the
   // expected colour item is queued before the block can possibly return it.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_channel.valid <= 1'b0;
      end else begin
         if (req_channel.valid && req_channel.ready)
            absorb_character(req_channel.character);
         if (!req_channel.valid || req_channel.ready) begin
            if (pending_characters.size() != 0 &&
                $urandom_range(0, 99) >= sender_idle_pct) begin
               req_channel.valid     <= 1'b1;
               req_channel.character <= pending_characters.pop_front();
            end else begin
               req_channel.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: stalls at random, and serves each requested long hold-off by
   // counting it down here while the driver keeps offering characters.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_channel.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_channel.ready <= 1'b0;
         hold_left         <= hold_left - 1;
      end else if (holds_granted != holds_asked) begin
         rsp_channel.ready <= 1'b0;
         hold_left         <= HOLD_CYCLES;
         holds_granted     <= holds_granted + 1;
      end else begin
         rsp_channel.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: every colour item taken is compared with the oldest prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_channel.valid && rsp_channel.ready) begin
         if (expected_colours.size() == 0) begin
            report_mismatch("colour item arrived with none expected");
         end else begin
            wanted_colour = expected_colours.pop_front();
            check_field("alpha", 32'(rsp_channel.alpha), 32'(wanted_colour.alpha),
                        !$isunknown(rsp_channel.alpha));
            check_field("red", 32'(rsp_channel.red), 32'(wanted_colour.red),
                        !$isunknown(rsp_channel.red));
            check_field("green", 32'(rsp_channel.green), 32'(wanted_colour.green),
                        !$isunknown(rsp_channel.green));
            check_field("blue", 32'(rsp_channel.blue), 32'(wanted_colour.blue),
                        !$isunknown(rsp_channel.blue));
            check_field("format_kind", 32'(rsp_channel.format_kind),
                        32'(wanted_colour.kind),
                        !$isunknown(rsp_channel.format_kind));
            check_field("strictly_valid", 32'(rsp_channel.strictly_valid),
                        32'(wanted_colour.strict),
                        !$isunknown(rsp_channel.strictly_valid));
         end
      end
   end

endmodule
